[rtl/vgfe_pkg.sv]
// vgfe_pkg: shared types, codes and constants for the voxel grid block
// used by vgfe_ctrl, vgfe_dp and voxel_grid_fill_and_exposure
// no dependencies
package vgfe_pkg;

    // default geometry and cell width
    localparam int GRID_SIDE_DEF   = 64;
    localparam int GRID_HEIGHT_DEF = 64;
    localparam int TYPE_BITS_DEF   = 5;

    // signed working width for coordinates and cuboid far corners
    localparam int CW = 10;

    // request kinds
    localparam logic [2:0] KIND_SET_CELL = 3'd0;
    localparam logic [2:0] KIND_SOLID    = 3'd1;
    localparam logic [2:0] KIND_SHELL    = 3'd2;
    localparam logic [2:0] KIND_EDGES    = 3'd3;
    localparam logic [2:0] KIND_QUERY    = 3'd4;

    // query read sequence: center, then +x,-x,+y,-y,+z,-z
    localparam logic [2:0] QSTEP_LAST = 3'd7;
    localparam logic signed [1:0] OFS_X [8] = '{2'sd0, 2'sd1, -2'sd1, 2'sd0,
                                                2'sd0, 2'sd0, 2'sd0, 2'sd0};
    localparam logic signed [1:0] OFS_Y [8] = '{2'sd0, 2'sd0, 2'sd0, 2'sd1,
                                                -2'sd1, 2'sd0, 2'sd0, 2'sd0};
    localparam logic signed [1:0] OFS_Z [8] = '{2'sd0, 2'sd0, 2'sd0, 2'sd0,
                                                2'sd0, 2'sd1, -2'sd1, 2'sd0};

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec_setup;
        logic fill_step;
        logic query_step;
        logic clear_step;
        logic load_result;
    } vgfe_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic kind_fill;
        logic kind_query;
        logic coord_valid;
        logic fill_empty;
        logic fill_last;
        logic query_last;
        logic clear_last;
    } vgfe_status_t;

endpackage

[rtl/vgfe_ctrl.sv]
// vgfe_ctrl: sequencing state machine for clear, fill, query and result handoff
// depends on vgfe_pkg
module vgfe_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  vgfe_pkg::vgfe_status_t status,
    output vgfe_pkg::vgfe_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_FILL  = 6'b001000,
        ST_QUERY = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.exec_setup = 1'b1;
                if (status.kind_fill && !status.fill_empty)
                begin
                    state_next = ST_FILL;
                end
                else if (status.kind_query && status.coord_valid)
                begin
                    state_next = ST_QUERY;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_QUERY:
            begin
                cmd.query_step = 1'b1;
                if (status.query_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/vgfe_dp.sv]
// vgfe_dp: request registers, cuboid walk, neighbor reads, cell memory and result register
// depends on vgfe_pkg
module vgfe_dp #(
    parameter int GRID_SIDE   = vgfe_pkg::GRID_SIDE_DEF,
    parameter int GRID_HEIGHT = vgfe_pkg::GRID_HEIGHT_DEF,
    parameter int TYPE_BITS   = vgfe_pkg::TYPE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vgfe_pkg::vgfe_cmd_t    cmd,
    output vgfe_pkg::vgfe_status_t status,
    input  logic [2:0]             kind,
    input  logic signed [7:0]      origin_x,
    input  logic signed [7:0]      origin_y,
    input  logic signed [7:0]      origin_z,
    input  logic [7:0]             extent_x,
    input  logic [7:0]             extent_y,
    input  logic [7:0]             extent_z,
    input  logic [4:0]             new_type,
    output logic [5:0]             exposure_mask,
    output logic                   is_solid,
    output logic [4:0]             cell_type,
    output logic                   coord_valid
);

    localparam int CW    = vgfe_pkg::CW;
    localparam int XB    = $clog2(GRID_SIDE);
    localparam int ZB    = $clog2(GRID_HEIGHT);
    localparam int AW    = 2 * XB + ZB;
    localparam int DEPTH = 1 << AW;
    localparam logic signed [CW-1:0] SIDE_C   = CW'(GRID_SIDE);
    localparam logic signed [CW-1:0] HGT_C    = CW'(GRID_HEIGHT);
    localparam logic signed [CW-1:0] SIDE_MAX = CW'(GRID_SIDE - 1);
    localparam logic signed [CW-1:0] HGT_MAX  = CW'(GRID_HEIGHT - 1);

    // request registers
    logic [2:0]           kind_reg;
    logic signed [CW-1:0] ox_reg, oy_reg, oz_reg;
    logic signed [CW-1:0] mx_reg, my_reg, mz_reg;
    logic [TYPE_BITS-1:0] type_reg;
    logic                 valid_reg;

    logic signed [CW-1:0] ox_c, oy_c, oz_c;

    assign ox_c = CW'(origin_x);
    assign oy_c = CW'(origin_y);
    assign oz_c = CW'(origin_z);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg  <= kind;
            ox_reg    <= ox_c;
            oy_reg    <= oy_c;
            oz_reg    <= oz_c;
            mx_reg    <= ox_c + $signed({2'b00, extent_x}) - CW'(1);
            my_reg    <= oy_c + $signed({2'b00, extent_y}) - CW'(1);
            mz_reg    <= oz_c + $signed({2'b00, extent_z}) - CW'(1);
            type_reg  <= TYPE_BITS'(new_type);
            valid_reg <= !ox_c[CW-1] && (ox_c < SIDE_C) &&
                         !oy_c[CW-1] && (oy_c < SIDE_C) &&
                         !oz_c[CW-1] && (oz_c < HGT_C);
        end
    end

    logic kind_set, kind_fill, kind_query;

    assign kind_set   = (kind_reg == vgfe_pkg::KIND_SET_CELL);
    assign kind_fill  = (kind_reg == vgfe_pkg::KIND_SOLID) ||
                        (kind_reg == vgfe_pkg::KIND_SHELL) ||
                        (kind_reg == vgfe_pkg::KIND_EDGES);
    assign kind_query = (kind_reg == vgfe_pkg::KIND_QUERY);

    // clipped cuboid bounds
    logic signed [CW-1:0] x0_c, x1_c, y0_c, y1_c, z0_c, z1_c;
    logic                 fill_empty;

    assign x0_c = ox_reg[CW-1] ? '0 : ox_reg;
    assign y0_c = oy_reg[CW-1] ? '0 : oy_reg;
    assign z0_c = oz_reg[CW-1] ? '0 : oz_reg;
    assign x1_c = (mx_reg > SIDE_MAX) ? SIDE_MAX : mx_reg;
    assign y1_c = (my_reg > SIDE_MAX) ? SIDE_MAX : my_reg;
    assign z1_c = (mz_reg > HGT_MAX) ? HGT_MAX : mz_reg;
    assign fill_empty = (x1_c < x0_c) || (y1_c < y0_c) || (z1_c < z0_c);

    // cuboid walk
    logic [XB-1:0] x_reg, y_reg, x0_reg, x1_reg, y0_reg, y1_reg;
    logic [ZB-1:0] z_reg, z1_reg;
    logic          fill_last, fill_hit;
    logic          on_x, on_y, on_z;
    logic [1:0]    on_cnt;
    logic signed [CW-1:0] xs, ys, zs;

    assign xs = $signed(CW'(x_reg));
    assign ys = $signed(CW'(y_reg));
    assign zs = $signed(CW'(z_reg));
    assign on_x = (xs == ox_reg) || (xs == mx_reg);
    assign on_y = (ys == oy_reg) || (ys == my_reg);
    assign on_z = (zs == oz_reg) || (zs == mz_reg);
    assign on_cnt = {1'b0, on_x} + {1'b0, on_y} + {1'b0, on_z};

    always_comb
    begin
        case (kind_reg)
            vgfe_pkg::KIND_SOLID: fill_hit = 1'b1;
            vgfe_pkg::KIND_SHELL: fill_hit = (on_cnt != 2'd0);
            vgfe_pkg::KIND_EDGES: fill_hit = on_cnt[1];
            default:              fill_hit = 1'b0;
        endcase
    end

    assign fill_last = (x_reg == x1_reg) && (y_reg == y1_reg) && (z_reg == z1_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.exec_setup)
        begin
            x0_reg <= x0_c[XB-1:0];
            x1_reg <= x1_c[XB-1:0];
            y0_reg <= y0_c[XB-1:0];
            y1_reg <= y1_c[XB-1:0];
            z1_reg <= z1_c[ZB-1:0];
            x_reg  <= x0_c[XB-1:0];
            y_reg  <= y0_c[XB-1:0];
            z_reg  <= z0_c[ZB-1:0];
        end
        else if (cmd.fill_step)
        begin
            if (x_reg != x1_reg)
            begin
                x_reg <= x_reg + XB'(1);
            end
            else
            begin
                x_reg <= x0_reg;
                if (y_reg != y1_reg)
                begin
                    y_reg <= y_reg + XB'(1);
                end
                else
                begin
                    y_reg <= y0_reg;
                    z_reg <= z_reg + ZB'(1);
                end
            end
        end
    end

    // query read sequence
    logic [2:0]           qstep_reg;
    logic                 rd_act_reg;
    logic [2:0]           rd_idx_reg;
    logic                 rd_inb_reg;
    logic signed [CW-1:0] nbx, nby, nbz;
    logic                 nb_inb;
    logic [AW-1:0]        rd_addr;

    assign nbx = ox_reg + CW'(vgfe_pkg::OFS_X[qstep_reg]);
    assign nby = oy_reg + CW'(vgfe_pkg::OFS_Y[qstep_reg]);
    assign nbz = oz_reg + CW'(vgfe_pkg::OFS_Z[qstep_reg]);
    assign nb_inb = !nbx[CW-1] && (nbx < SIDE_C) &&
                    !nby[CW-1] && (nby < SIDE_C) &&
                    !nbz[CW-1] && (nbz < HGT_C);
    assign rd_addr = {nbz[ZB-1:0], nby[XB-1:0], nbx[XB-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qstep_reg  <= '0;
            rd_act_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec_setup)
            begin
                qstep_reg <= '0;
            end
            else if (cmd.query_step)
            begin
                qstep_reg <= qstep_reg + 3'd1;
            end
            rd_act_reg <= cmd.query_step && (qstep_reg != vgfe_pkg::QSTEP_LAST);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= qstep_reg;
        rd_inb_reg <= nb_inb;
    end

    // clearing sweep after reset
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // cell memory, one write and one registered read per cycle
    logic [TYPE_BITS-1:0] mem [DEPTH];
    logic [TYPE_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;
    logic [TYPE_BITS-1:0] wr_data;

    always_comb
    begin
        if (cmd.clear_step)
        begin
            mem_we  = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if (cmd.fill_step)
        begin
            mem_we  = fill_hit;
            wr_addr = {z_reg, y_reg, x_reg};
            wr_data = type_reg;
        end
        else
        begin
            mem_we  = cmd.exec_setup && kind_set && valid_reg;
            wr_addr = {oz_reg[ZB-1:0], oy_reg[XB-1:0], ox_reg[XB-1:0]};
            wr_data = type_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // query accumulation
    logic [TYPE_BITS-1:0] qtype_reg;
    logic [5:0]           qmask_reg;

    always_ff @(posedge clk)
    begin
        if (rd_act_reg)
        begin
            if (rd_idx_reg == 3'd0)
            begin
                qtype_reg <= rd_data_reg;
            end
            for (int d = 0; d < 6; d++)
            begin
                if (rd_idx_reg == 3'(d + 1))
                begin
                    qmask_reg[d] <= !rd_inb_reg || (rd_data_reg == '0);
                end
            end
        end
    end

    // result register
    logic       show_query;
    logic [7:0] qtype_wide;
    logic [5:0] res_mask_reg;
    logic       res_solid_reg;
    logic [4:0] res_type_reg;
    logic       res_valid_reg;

    assign show_query = kind_query && valid_reg;
    assign qtype_wide = 8'(qtype_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            res_mask_reg  <= show_query ? qmask_reg : 6'd0;
            res_solid_reg <= show_query && (qtype_reg != '0);
            res_type_reg  <= show_query ? qtype_wide[4:0] : 5'd0;
            res_valid_reg <= valid_reg;
        end
    end

    assign exposure_mask = res_mask_reg;
    assign is_solid      = res_solid_reg;
    assign cell_type     = res_type_reg;
    assign coord_valid   = res_valid_reg;

    assign status.kind_fill   = kind_fill;
    assign status.kind_query  = kind_query;
    assign status.coord_valid = valid_reg;
    assign status.fill_empty  = fill_empty;
    assign status.fill_last   = fill_last;
    assign status.query_last  = (qstep_reg == vgfe_pkg::QSTEP_LAST);
    assign status.clear_last  = (clr_cnt_reg == {AW{1'b1}});

endmodule

[rtl/voxel_grid_fill_and_exposure.sv]
// voxel_grid_fill_and_exposure: top level, controller plus datapath
// depends on vgfe_pkg, vgfe_ctrl, vgfe_dp
//
// Keeps a voxel grid of GRID_SIDE x GRID_SIDE x GRID_HEIGHT cells, each holding a
// TYPE_BITS-wide block type (0 = empty), in one memory with one write port and one
// read port, addressed {z, y, x} with 2*clog2(GRID_SIDE)+clog2(GRID_HEIGHT) address
// bits. After reset the block sweeps that memory to zero, one entry per cycle, and
// holds in_ready low until the sweep ends. Requests are taken one at a time; each
// gives exactly one result. Set cell and undefined kinds go from setup straight to
// the result handoff; fills first walk every cell of the cuboid clipped to the grid
// (no walk when nothing is left); queries with a valid origin first read the center
// and six neighbors one per cycle through the one registered memory read port. The
// input side is free again in the cycle after a result is loaded into the output
// register, so the next request runs while a result waits; a new result waits only
// if the previous one has not been taken.
module voxel_grid_fill_and_exposure #(
    parameter int GRID_SIDE   = vgfe_pkg::GRID_SIDE_DEF,
    parameter int GRID_HEIGHT = vgfe_pkg::GRID_HEIGHT_DEF,
    parameter int TYPE_BITS   = vgfe_pkg::TYPE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        kind,
    input  logic signed [7:0] origin_x,
    input  logic signed [7:0] origin_y,
    input  logic signed [7:0] origin_z,
    input  logic [7:0]        extent_x,
    input  logic [7:0]        extent_y,
    input  logic [7:0]        extent_z,
    input  logic [4:0]        new_type,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [5:0]        exposure_mask,
    output logic              is_solid,
    output logic [4:0]        cell_type,
    output logic              coord_valid
);

    vgfe_pkg::vgfe_cmd_t    cmd;
    vgfe_pkg::vgfe_status_t status;

    // sequencing: clear sweep, request setup, cuboid walk, neighbor reads, handoff
    vgfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // request registers, cell memory, exposure accumulation and result register
    vgfe_dp #(
        .GRID_SIDE   (GRID_SIDE),
        .GRID_HEIGHT (GRID_HEIGHT),
        .TYPE_BITS   (TYPE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (kind),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .origin_z      (origin_z),
        .extent_x      (extent_x),
        .extent_y      (extent_y),
        .extent_z      (extent_z),
        .new_type      (new_type),
        .exposure_mask (exposure_mask),
        .is_solid      (is_solid),
        .cell_type     (cell_type),
        .coord_valid   (coord_valid)
    );

    // one request in flight: accepting leaves the idle state at once
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    // an origin outside the grid reports nothing but the invalid flag
    a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !coord_valid) |->
        (exposure_mask == 6'd0) && !is_solid && (cell_type == 5'd0))
        else $error("invalid origin with nonzero query fields");

    // the controller issues at most one datapath command per cycle
    a_no_cmd_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_item, cmd.exec_setup, cmd.fill_step, cmd.query_step,
                  cmd.clear_step, cmd.load_result}))
        else $error("controller issued overlapping datapath commands");

endmodule
